// File: hdl/fiu_pkg.sv
// ----------------------------------------------------------------------------
// fiu_pkg - shared types and constants for the flood image uniformity block
// Pixel and field widths, register reset value, percent scaling and the
// status group returned by the shared divide unit.
// ----------------------------------------------------------------------------
package fiu_pkg;

	// default pixel width and build limits
	localparam int PIXEL_BITS_DEF  = 16;
	localparam int MAX_WIDTH_DEF   = 4096;
	localparam int WINDOW_SIZE_DEF = 5;

	// row width register
	localparam int                    CFG_WIDTH_BITS = 13;
	localparam logic [CFG_WIDTH_BITS-1:0] WIDTH_RESET = CFG_WIDTH_BITS'(128);

	// percent result: 100 % with 8 fractional bits, 15 quotient bits
	localparam int PCT_BITS  = 15;
	localparam int PCT_SCALE = 25600;
	localparam int PCT_CNT_BITS = $clog2(PCT_BITS);

	// status of the shared divide unit
	typedef struct packed {
		logic busy;
		logic done;
		logic zero;
	} fiu_div_stat_t;

endpackage

// File: hdl/fiu_if.sv
// ----------------------------------------------------------------------------
// fiu_if - valid/ready channels of the flood image uniformity block
// Pixel stream in, one uniformity result per image out.
// ----------------------------------------------------------------------------
interface fiu_pixel_if #(
	parameter int PIXEL_BITS = fiu_pkg::PIXEL_BITS_DEF
);
	logic                  valid;
	logic                  ready;
	logic [PIXEL_BITS-1:0] pixel;
	logic                  last_pixel;

	modport source (output valid, output pixel, output last_pixel, input ready);
	modport sink   (input valid, input pixel, input last_pixel, output ready);
endinterface

interface fiu_result_if #(
	parameter int PIXEL_BITS = fiu_pkg::PIXEL_BITS_DEF
);
	logic                          valid;
	logic                          ready;
	logic [fiu_pkg::PCT_BITS-1:0]  integral_percent;
	logic [fiu_pkg::PCT_BITS-1:0]  differential_percent;
	logic [PIXEL_BITS-1:0]         image_max;
	logic [PIXEL_BITS-1:0]         image_min;
	logic [PIXEL_BITS-1:0]         window_range_max;
	logic [PIXEL_BITS-1:0]         window_range_min;
	logic                          integral_zero_sum;
	logic                          differential_zero_sum;

	modport source (output valid, output integral_percent, output differential_percent,
		output image_max, output image_min, output window_range_max,
		output window_range_min, output integral_zero_sum,
		output differential_zero_sum, input ready);
	modport sink (input valid, input integral_percent, input differential_percent,
		input image_max, input image_min, input window_range_max,
		input window_range_min, input integral_zero_sum,
		input differential_zero_sum, output ready);
endinterface

// File: hdl/fiu_div.sv
// ----------------------------------------------------------------------------
// fiu_div - shared uniformity ratio unit
// Computes round(25600 * (hi - lo) / (hi + lo)) with halves rounded up,
// by one constant multiply and a restoring divide of one bit per cycle.
// A zero sum, or hi below lo, gives a quotient of zero.
// ----------------------------------------------------------------------------
module fiu_div #(
	parameter int PIXEL_BITS = fiu_pkg::PIXEL_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [PIXEL_BITS-1:0]          hi,
	input  logic [PIXEL_BITS-1:0]          lo,
	output fiu_pkg::fiu_div_stat_t         stat,
	output logic [fiu_pkg::PCT_BITS-1:0]   quot
);
	import fiu_pkg::*;

	localparam int DEN_BITS  = PIXEL_BITS + 1;
	localparam int PROD_BITS = PIXEL_BITS + PCT_BITS;
	localparam int NUM_BITS  = PIXEL_BITS + PCT_BITS + 2;

	typedef enum logic [3:0] {
		D_IDLE = 4'b0001,
		D_MUL  = 4'b0010,
		D_LOAD = 4'b0100,
		D_RUN  = 4'b1000
	} div_state_t;

	div_state_t               state_q;
	logic [PIXEL_BITS-1:0]    hi_q, lo_q;
	logic [PROD_BITS-1:0]     prod_q;
	logic [DEN_BITS-1:0]      den_q;
	logic                     skip_q;
	logic                     zero_q;
	logic                     done_q;
	logic [NUM_BITS-1:0]      rem_q;
	logic [NUM_BITS-1:0]      dsh_q;
	logic [PCT_CNT_BITS-1:0]  cnt_q;
	logic [PCT_BITS-1:0]      quot_q;
	logic                     ge;
	logic [DEN_BITS-1:0]      den_sum;

	assign ge      = (rem_q >= dsh_q);
	assign den_sum = DEN_BITS'(hi_q) + DEN_BITS'(lo_q);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= D_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				D_IDLE: if (start) state_q <= D_MUL;
				D_MUL:  state_q <= D_LOAD;
				D_LOAD: begin
					if (skip_q) begin
						state_q <= D_IDLE;
						done_q  <= 1'b1;
					end else begin
						state_q <= D_RUN;
					end
				end
				D_RUN: begin
					if (cnt_q == '0) begin
						state_q <= D_IDLE;
						done_q  <= 1'b1;
					end
				end
				default: state_q <= D_IDLE;
			endcase
		end
	end

	// datapath: operand capture, scaling multiply, restoring divide
	always_ff @(posedge clk) begin
		case (state_q)
			D_IDLE: begin
				if (start) begin
					hi_q <= hi;
					lo_q <= lo;
				end
			end
			D_MUL: begin
				prod_q <= PROD_BITS'(hi_q - lo_q) * PROD_BITS'(PCT_SCALE);
				den_q  <= den_sum;
				skip_q <= (den_sum == '0) || (hi_q < lo_q);
				zero_q <= (den_sum == '0);
			end
			D_LOAD: begin
				// numerator 2*num + den, divisor 2*den lined up with the top quotient bit
				rem_q  <= NUM_BITS'({prod_q, 1'b0}) + NUM_BITS'(den_q);
				dsh_q  <= NUM_BITS'(den_q) << PCT_BITS;
				cnt_q  <= PCT_CNT_BITS'(PCT_BITS - 1);
				quot_q <= '0;
			end
			D_RUN: begin
				if (ge) rem_q <= rem_q - dsh_q;
				quot_q <= {quot_q[PCT_BITS-2:0], ge};
				dsh_q  <= dsh_q >> 1;
				cnt_q  <= cnt_q - 1'b1;
			end
			default: ;
		endcase
	end

	assign stat.busy = (state_q != D_IDLE);
	assign stat.done = done_q;
	assign stat.zero = zero_q;
	assign quot      = quot_q;

endmodule

// File: hdl/flood_image_uniformity.sv
// ----------------------------------------------------------------------------
// flood_image_uniformity - NEMA integral and differential uniformity
// Tracks pixel extremes and per-row sliding window ranges over a raster
// flood image; on the last pixel reports both uniformity percentages.
// ----------------------------------------------------------------------------
// Pixels: once a full window is in the row, a pixel is compared with one
// history entry per scan step, else it goes straight to the range step.
// Result: the last pixel adds two ratio passes (divide skipped on a zero
// sum) on the shared multiply/divide unit, then one output register.
// Reset: asynchronous, active low; clears column and all extremes, width = 128.
module flood_image_uniformity #(
	parameter int PIXEL_BITS  = fiu_pkg::PIXEL_BITS_DEF,
	parameter int MAX_WIDTH   = fiu_pkg::MAX_WIDTH_DEF,
	parameter int WINDOW_SIZE = fiu_pkg::WINDOW_SIZE_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [fiu_pkg::CFG_WIDTH_BITS-1:0] cfg_wdata,
	fiu_pixel_if.sink                          pixels,
	fiu_result_if.source                       results
);
	import fiu_pkg::*;

	localparam int HIST_LEN = WINDOW_SIZE - 1;
	localparam int HB       = (HIST_LEN > 1) ? $clog2(HIST_LEN) : 1;
	localparam int CW       = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int WW       = (CW + 1 > CFG_WIDTH_BITS) ? CW + 1 : CFG_WIDTH_BITS;

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_SCAN  = 6'b000010,
		S_RANGE = 6'b000100,
		S_DIVI  = 6'b001000,
		S_DIVD  = 6'b010000,
		S_OUT   = 6'b100000
	} state_t;

	state_t                    state_q;
	logic [CFG_WIDTH_BITS-1:0] image_width_q;
	logic [PIXEL_BITS-1:0]     hist_q [HIST_LEN];
	logic [CW-1:0]             col_q;
	logic [PIXEL_BITS-1:0]     run_max_q, run_min_q;
	logic [PIXEL_BITS-1:0]     rng_max_q, rng_min_q;
	logic                      first_q;
	logic [PIXEL_BITS-1:0]     pix_q;
	logic                      last_q;
	logic                      win_q;
	logic [HB-1:0]             idx_q;
	logic [PIXEL_BITS-1:0]     hi_q, lo_q;
	logic [PCT_BITS-1:0]       int_pct_q;
	logic                      int_zero_q;
	logic [PCT_BITS-1:0]       dif_pct_q;
	logic                      dif_zero_q;

	// result register
	logic                      res_valid_q;
	logic [PCT_BITS-1:0]       res_int_pct_q, res_dif_pct_q;
	logic [PIXEL_BITS-1:0]     res_max_q, res_min_q, res_rmax_q, res_rmin_q;
	logic                      res_int_zero_q, res_dif_zero_q;

	logic                      in_xfer;
	logic                      res_load;
	logic [WW-1:0]             width_eff;
	logic                      row_end;
	logic [PIXEL_BITS-1:0]     hist_rd;
	logic [PIXEL_BITS-1:0]     win_range;
	logic [PIXEL_BITS-1:0]     rmax_eff, rmin_eff;
	logic                      div_start;
	logic [PIXEL_BITS-1:0]     div_hi, div_lo;
	fiu_div_stat_t             div_stat;
	logic [PCT_BITS-1:0]       div_quot;

	assign pixels.ready = (state_q == S_IDLE);
	assign in_xfer      = pixels.valid && pixels.ready;
	assign res_load     = (state_q == S_OUT) && (!res_valid_q || results.ready);

	// row length, saturated to the build limit
	assign width_eff = (WW'(image_width_q) > WW'(MAX_WIDTH)) ? WW'(MAX_WIDTH)
		: WW'(image_width_q);
	assign row_end   = (WW'(col_q) + WW'(1)) >= width_eff;

	assign hist_rd   = hist_q[idx_q];
	assign win_range = hi_q - lo_q;

	// no complete window in the image: report range extremes as zero
	assign rmax_eff = (rng_max_q < rng_min_q) ? '0 : rng_max_q;
	assign rmin_eff = (rng_max_q < rng_min_q) ? '0 : rng_min_q;

	// shared ratio unit: integral pass first, differential pass second
	assign div_start = ((state_q == S_RANGE) && last_q) || ((state_q == S_DIVI) && div_stat.done);
	assign div_hi    = (state_q == S_RANGE) ? run_max_q : rmax_eff;
	assign div_lo    = (state_q == S_RANGE) ? run_min_q : rmin_eff;

	fiu_div #(
		.PIXEL_BITS (PIXEL_BITS)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.hi     (div_hi),
		.lo     (div_lo),
		.stat   (div_stat),
		.quot   (div_quot)
	);

	// width register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q <= WIDTH_RESET;
		end else if (cfg_we) begin
			image_width_q <= cfg_wdata;
		end
	end

	// sequencer and frame state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			col_q     <= '0;
			run_max_q <= '0;
			run_min_q <= '1;
			rng_max_q <= '0;
			rng_min_q <= '1;
			first_q   <= 1'b1;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						if (first_q) begin
							run_max_q <= pixels.pixel;
							run_min_q <= pixels.pixel;
							first_q   <= 1'b0;
						end else begin
							if (pixels.pixel > run_max_q) run_max_q <= pixels.pixel;
							if (pixels.pixel < run_min_q) run_min_q <= pixels.pixel;
						end
						col_q   <= row_end ? '0 : col_q + 1'b1;
						state_q <= (WW'(col_q) >= WW'(HIST_LEN)) ? S_SCAN : S_RANGE;
					end
				end
				S_SCAN: begin
					if (idx_q == HB'(HIST_LEN - 1)) state_q <= S_RANGE;
				end
				S_RANGE: begin
					if (win_q) begin
						if (win_range > rng_max_q) rng_max_q <= win_range;
						if (win_range < rng_min_q) rng_min_q <= win_range;
					end
					state_q <= last_q ? S_DIVI : S_IDLE;
				end
				S_DIVI: begin
					if (div_stat.done) state_q <= S_DIVD;
				end
				S_DIVD: begin
					if (div_stat.done) state_q <= S_OUT;
				end
				S_OUT: begin
					// result handed over: start a fresh image
					if (res_load) begin
						state_q   <= S_IDLE;
						col_q     <= '0;
						run_max_q <= '0;
						run_min_q <= '1;
						rng_max_q <= '0;
						rng_min_q <= '1;
						first_q   <= 1'b1;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// pixel capture, window scan and history shift
	// history entries older than the row start are never read: a window is
	// only scanned once the row has filled the whole history
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			pix_q  <= pixels.pixel;
			last_q <= pixels.last_pixel;
			win_q  <= (WW'(col_q) >= WW'(HIST_LEN));
			hi_q   <= pixels.pixel;
			lo_q   <= pixels.pixel;
			idx_q  <= '0;
		end
		if (state_q == S_SCAN) begin
			if (hist_rd > hi_q) hi_q <= hist_rd;
			if (hist_rd < lo_q) lo_q <= hist_rd;
			idx_q <= idx_q + 1'b1;
		end
		if (state_q == S_RANGE) begin
			for (int i = 0; i < HIST_LEN - 1; i++) hist_q[i] <= hist_q[i+1];
			hist_q[HIST_LEN-1] <= pix_q;
		end
		if ((state_q == S_DIVI) && div_stat.done) begin
			int_pct_q  <= div_quot;
			int_zero_q <= div_stat.zero;
		end
		if ((state_q == S_DIVD) && div_stat.done) begin
			dif_pct_q  <= div_quot;
			dif_zero_q <= div_stat.zero;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (res_load) begin
			res_valid_q <= 1'b1;
		end else if (results.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			res_int_pct_q  <= int_pct_q;
			res_dif_pct_q  <= dif_pct_q;
			res_max_q      <= run_max_q;
			res_min_q      <= run_min_q;
			res_rmax_q     <= rmax_eff;
			res_rmin_q     <= rmin_eff;
			res_int_zero_q <= int_zero_q;
			res_dif_zero_q <= dif_zero_q;
		end
	end

	assign results.valid                 = res_valid_q;
	assign results.integral_percent      = res_int_pct_q;
	assign results.differential_percent  = res_dif_pct_q;
	assign results.image_max             = res_max_q;
	assign results.image_min             = res_min_q;
	assign results.window_range_max      = res_rmax_q;
	assign results.window_range_min      = res_rmin_q;
	assign results.integral_zero_sum     = res_int_zero_q;
	assign results.differential_zero_sum = res_dif_zero_q;

	// checks
	a_div_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_stat.busy)
		else $error("ratio unit started while busy");

	a_res_from_out: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> $past(state_q == S_OUT))
		else $error("result raised outside the output step");

	a_scan_index: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> (32'(idx_q) < HIST_LEN))
		else $error("window scan index beyond history");

	a_single_result: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && !results.ready) |=> res_valid_q && $stable(res_int_pct_q))
		else $error("pending result lost");

endmodule

// File: bench/fiu_result_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fiu_result_checker - uniformity predictor and result comparison
// Watches the row width writes and every pixel transfer, keeps its own copy
// of the frame state and queues the result expected at each last pixel.
// Each result transfer is compared field by field with the oldest queued one.
// ----------------------------------------------------------------------------
module fiu_result_checker (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [fiu_pkg::CFG_WIDTH_BITS-1:0] cfg_wdata,
	fiu_pixel_if                               pixels,
	fiu_result_if                              results,
	output int                                 fail_count,
	output int                                 waiting
);
	import fiu_pkg::*;

	localparam int PIX      = PIXEL_BITS_DEF;
	localparam int HIST_LEN = WINDOW_SIZE_DEF - 1;
	localparam logic [PIX-1:0] PIX_ONES = '1;

	typedef struct packed {
		logic [PCT_BITS-1:0] integral_percent;
		logic [PCT_BITS-1:0] differential_percent;
		logic [PIX-1:0]      image_max;
		logic [PIX-1:0]      image_min;
		logic [PIX-1:0]      window_range_max;
		logic [PIX-1:0]      window_range_min;
		logic                integral_zero_sum;
		logic                differential_zero_sum;
	} uniformity_t;

	// frame state of the predictor
	logic [CFG_WIDTH_BITS-1:0] row_width;
	logic [PIX-1:0]            history [HIST_LEN];
	int unsigned               column;
	logic [PIX-1:0]            pix_max;
	logic [PIX-1:0]            pix_min;
	logic [PIX-1:0]            span_max;
	logic [PIX-1:0]            span_min;
	logic                      fresh_frame;
	uniformity_t               expected_results [$];
	int                        errors;

	assign fail_count = errors;

	task automatic clear_frame();
		for (int i = 0; i < HIST_LEN; i++) history[i] = '0;
		column      = 0;
		pix_max     = '0;
		pix_min     = PIX_ONES;
		span_max    = '0;
		span_min    = PIX_ONES;
		fresh_frame = 1'b1;
	endtask

	// (hi-lo)/(hi+lo) scaled to percent with 8 fraction bits, halves rounded up
	function automatic logic [PCT_BITS-1:0] ratio_q8(input logic [PIX-1:0] hi,
			input logic [PIX-1:0] lo, output logic zero);
		logic [63:0] den;
		logic [63:0] num;
		den  = 64'(hi) + 64'(lo);
		zero = (den == 0);
		if (den == 0 || hi < lo) return '0;
		num = 64'(hi - lo) * PCT_SCALE;
		return PCT_BITS'((num * 2 + den) / (den * 2));
	endfunction

	// fold one pixel into the frame state, queue a result on the last one
	task automatic absorb_pixel(input logic [PIX-1:0] p, input logic last);
		int unsigned    eff_width;
		logic [PIX-1:0] hi;
		logic [PIX-1:0] lo;
		logic [PIX-1:0] rmax;
		logic [PIX-1:0] rmin;
		uniformity_t    res;
		eff_width = (row_width > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : row_width;

		if (fresh_frame) begin
			pix_max     = p;
			pix_min     = p;
			fresh_frame = 1'b0;
		end else begin
			if (p > pix_max) pix_max = p;
			if (p < pix_min) pix_min = p;
		end

		// window history restarts with every row
		if (column == 0)
			for (int i = 0; i < HIST_LEN; i++) history[i] = '0;

		if (column >= HIST_LEN) begin
			hi = p;
			lo = p;
			for (int i = 0; i < HIST_LEN; i++) begin
				if (history[i] > hi) hi = history[i];
				if (history[i] < lo) lo = history[i];
			end
			if (hi - lo > span_max) span_max = hi - lo;
			if (hi - lo < span_min) span_min = hi - lo;
		end

		for (int i = 0; i + 1 < HIST_LEN; i++) history[i] = history[i + 1];
		history[HIST_LEN - 1] = p;

		if (column + 1 >= eff_width) column = 0;
		else column++;

		if (last) begin
			rmax = span_max;
			rmin = span_min;
			// no complete window seen in this image
			if (rmax < rmin) begin
				rmax = '0;
				rmin = '0;
			end
			res.integral_percent     = ratio_q8(pix_max, pix_min, res.integral_zero_sum);
			res.differential_percent = ratio_q8(rmax, rmin, res.differential_zero_sum);
			res.image_max            = pix_max;
			res.image_min            = pix_min;
			res.window_range_max     = rmax;
			res.window_range_min     = rmin;
			expected_results.push_back(res);
			clear_frame();
		end
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			errors++;
			$display("%0t: %s expected %0d got %0d", $time, name, want, got);
		end
	endtask

	task automatic compare_result();
		uniformity_t want;
		if (expected_results.size() == 0) begin
			errors++;
			$display("%0t: result transfer with none expected, integral %0d got",
				$time, results.integral_percent);
			return;
		end
		want = expected_results.pop_front();
		check_field("integral_percent", want.integral_percent, results.integral_percent);
		check_field("differential_percent", want.differential_percent,
			results.differential_percent);
		check_field("image_max", want.image_max, results.image_max);
		check_field("image_min", want.image_min, results.image_min);
		check_field("window_range_max", want.window_range_max, results.window_range_max);
		check_field("window_range_min", want.window_range_min, results.window_range_min);
		check_field("integral_zero_sum", want.integral_zero_sum, results.integral_zero_sum);
		check_field("differential_zero_sum", want.differential_zero_sum,
			results.differential_zero_sum);
	endtask

	initial errors = 0;

	// sample transfers and register writes at each rising edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_width = WIDTH_RESET;
			clear_frame();
			expected_results.delete();
			waiting <= 0;
		end else begin
			if (results.valid && results.ready) compare_result();
			if (pixels.valid && pixels.ready) absorb_pixel(pixels.pixel, pixels.last_pixel);
			if (cfg_we) row_width = cfg_wdata;
			waiting <= expected_results.size();
		end
	end

endmodule

// File: bench/flood_image_uniformity_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flood_image_uniformity_tb - stimulus and verdict for the uniformity block
// Sends a short directed set of images, then random flood images over a run
// of row widths from zero up to the register maximum, with random gaps on
// both channels and one long output stall. Checking sits in the checker.
// ----------------------------------------------------------------------------
module flood_image_uniformity_tb;
	import fiu_pkg::*;

	localparam int CLK_PERIOD    = 20;
	localparam int HOLD_CYCLES   = 800;
	localparam int PHASE_ITEMS   = 80;
	localparam int SETTLE_CYCLES = 20;
	localparam int DRAIN_LIMIT   = 20000;
	localparam int TAIL_CYCLES   = 60;
	localparam int NUM_PHASES    = 14;
	localparam int NUM_DIRECTED  = 19;

	typedef enum int {STYLE_NOISE, STYLE_FLAT, STYLE_EXTREME} pixel_style_t;

	// {last_pixel, pixel}: zero image, full swing, flat, early end, tiny image
	localparam logic [16:0] DIRECTED [NUM_DIRECTED] = '{
		{1'b1, 16'h0000},
		{1'b0, 16'hFFFF}, {1'b0, 16'h0000}, {1'b0, 16'hFFFF}, {1'b0, 16'h0000},
		{1'b1, 16'hFFFF},
		{1'b0, 16'hFFFF}, {1'b0, 16'hFFFF}, {1'b0, 16'hFFFF}, {1'b0, 16'hFFFF},
		{1'b1, 16'hFFFF},
		{1'b0, 16'h5555}, {1'b0, 16'hAAAA}, {1'b0, 16'h8000}, {1'b0, 16'h7FFF},
		{1'b0, 16'h0001}, {1'b1, 16'hFFFE},
		{1'b0, 16'h0000}, {1'b1, 16'h0001}
	};

	localparam int PHASE_WIDTHS [NUM_PHASES] = '{
		5, 0, 7, 4097, 1, 6, 8191, 2, 4, 128, 8, 4096, 5, 3
	};

	logic                      clk = 1'b0;
	logic                      arst_n;
	logic                      cfg_we;
	logic [CFG_WIDTH_BITS-1:0] cfg_wdata;
	int                        send_idle_pct;
	int                        recv_idle_pct;
	logic                      hold_req;
	logic                      hold_ack;
	int                        fail_count;
	int                        waiting;

	fiu_pixel_if  pix_ch ();
	fiu_result_if res_ch ();

	flood_image_uniformity dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.pixels    (pix_ch),
		.results   (res_ch)
	);

	fiu_result_checker uniformity_chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.pixels     (pix_ch),
		.results    (res_ch),
		.fail_count (fail_count),
		.waiting    (waiting)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// run limit
	initial begin
		#(10_000_000);
		$display("TEST FAILED");
		$finish;
	end

	// pixel values shaped like a flood image, pure noise or rail to rail
	function automatic logic [15:0] flood_pixel(input pixel_style_t style,
			input logic [15:0] base);
		case (style)
			STYLE_NOISE: return 16'($urandom);
			STYLE_FLAT:  return base ^ 16'($urandom_range(0, 63));
			default: begin
				case ($urandom_range(0, 3))
					0:       return 16'h0000;
					1:       return 16'hFFFF;
					default: return 16'($urandom);
				endcase
			end
		endcase
	endfunction

	// mostly whole rows for widths 2 to 16, otherwise often an image that stops mid-row
	function automatic int image_length(input int width);
		int row;
		row = (width > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : width;
		if (row <= 1) return $urandom_range(1, 12);
		if (row <= 16) begin
			if ($urandom_range(99) < 85) return row * $urandom_range(1, 4);
			return $urandom_range(1, 3 * row + 2);
		end
		if (row <= 128 && $urandom_range(99) < 30) return row * $urandom_range(1, 2);
		return $urandom_range(1, 300);
	endfunction

	// one pixel transfer, with an optional gap before it
	task automatic send_pixel(input logic [15:0] value, input logic last);
		if ($urandom_range(99) < send_idle_pct) begin
			pix_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		pix_ch.valid      <= 1'b1;
		pix_ch.pixel      <= value;
		pix_ch.last_pixel <= last;
		do @(posedge clk); while (pix_ch.ready !== 1'b1);
	endtask

	task automatic send_image(input int len, input pixel_style_t style);
		logic [15:0] base;
		base = 16'($urandom);
		for (int i = 0; i < len; i++)
			send_pixel(flood_pixel(style, base), i == len - 1);
	endtask

	// register write once all results are out and the block has settled
	task automatic set_width(input int value);
		pix_ch.valid <= 1'b0;
		@(posedge clk);
		while (waiting != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= CFG_WIDTH_BITS'(value);
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	task automatic run_phase(input int width, input int budget);
		int sent;
		int len;
		sent = 0;
		set_width(width);
		while (sent < budget) begin
			len = image_length(width);
			send_image(len, pixel_style_t'($urandom_range(0, 2)));
			sent += len;
		end
	endtask

	// output held off while short images keep coming, so the input backs up
	task automatic squeeze_output();
		hold_req <= ~hold_req;
		for (int i = 0; i < 10; i++)
			send_image(6, STYLE_NOISE);
	endtask

	// result side: random back-pressure, or one long hold when asked
	initial begin : result_sink
		res_ch.ready = 1'b0;
		hold_ack     = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req != hold_ack) begin
				hold_ack     <= hold_req;
				res_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	initial begin : stimulus
		int k;
		arst_n            = 1'b0;
		cfg_we            = 1'b0;
		cfg_wdata         = '0;
		pix_ch.valid      = 1'b0;
		pix_ch.pixel      = '0;
		pix_ch.last_pixel = 1'b0;
		hold_req          = 1'b0;
		send_idle_pct     = 26;
		recv_idle_pct     = 50;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed images at the reset width
		for (k = 0; k < NUM_DIRECTED; k++)
			send_pixel(DIRECTED[k][15:0], DIRECTED[k][16]);

		// random images over the width list, idling swapped then switched off
		for (k = 0; k < NUM_PHASES; k++) begin
			if (k == 5) begin
				send_idle_pct <= 50;
				recv_idle_pct <= 26;
			end
			if (k == 10) begin
				send_idle_pct <= 0;
				recv_idle_pct <= 0;
			end
			run_phase(PHASE_WIDTHS[k], PHASE_ITEMS);
			if (k == 0) squeeze_output();
		end

		// drain
		pix_ch.valid <= 1'b0;
		@(posedge clk);
		for (k = 0; k < DRAIN_LIMIT && waiting != 0; k++) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (fail_count == 0 && waiting == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
